// ----- rtl/core/rcpc_pkg.sv -----
// rcpc_pkg: shared constants, types and helpers of the ray/convex polygon clip unit
// no dependencies; used by rcpc_div and ray_convex_polygon_clip_unit
package rcpc_pkg;

	localparam int MAX_FACES  = 8;
	localparam int FRAC_BITS  = 16;
	localparam int FACE_IDX_W = $clog2(MAX_FACES);
	localparam int CNT_W      = $clog2(MAX_FACES + 1);
	localparam int PROD_W     = 66;
	localparam int FQ_W       = PROD_W - FRAC_BITS;
	localparam int ACC_W      = FQ_W + 1;
	localparam int DIVD_W     = 32 + FRAC_BITS;
	localparam int QUO_W      = 31;

	localparam logic [1:0] KIND_FACE  = 2'd0;
	localparam logic [1:0] KIND_XFORM = 2'd1;
	localparam logic [1:0] KIND_RAY   = 2'd2;

	localparam logic signed [31:0] MAX_S32 = 32'sh7fffffff;
	localparam logic signed [31:0] MIN_S32 = 32'sh80000000;
	localparam logic [30:0]        MAX_Q31 = 31'h7fffffff;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOCAL,
		ST_FACE,
		ST_EVAL,
		ST_CMP,
		ST_DIV,
		ST_NEXT,
		ST_WORLD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       vld;
		logic       last;
		logic [2:0] op;
	} mtag_t;

	typedef struct packed {
		logic             sat;
		logic [QUO_W-1:0] mag;
	} quo_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-32:0] hi;
		hi = v[ACC_W-1:31];
		if (hi == '0 || hi == '1) begin
			return v[31:0];
		end
		return v[ACC_W-1] ? MIN_S32 : MAX_S32;
	endfunction

	function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

endpackage

// ----- rtl/core/rcpc_if.sv -----
// rcpc_cmd_if / rcpc_res_if: valid/ready channels of the clip unit
// no dependencies
interface rcpc_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [2:0]         face_slot;
	logic signed [31:0] x_a;
	logic signed [31:0] y_a;
	logic signed [31:0] x_b;
	logic signed [31:0] y_b;
	logic [30:0]        max_fraction;
	logic [3:0]         face_count;

	modport source (output valid, kind, face_slot, x_a, y_a, x_b, y_b, max_fraction,
		face_count, input ready);
	modport sink (input valid, kind, face_slot, x_a, y_a, x_b, y_b, max_fraction,
		face_count, output ready);
endinterface

interface rcpc_res_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [30:0]        fraction;
	logic signed [31:0] normal_x;
	logic signed [31:0] normal_y;

	modport source (output valid, hit, fraction, normal_x, normal_y, input ready);
	modport sink (input valid, hit, fraction, normal_x, normal_y, output ready);
endinterface

// ----- rtl/core/rcpc_div.sv -----
// rcpc_div: radix-2 restoring divider for the clip quotients, one bit a cycle
// depends on rcpc_pkg
module rcpc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rcpc_pkg::DIVD_W-1:0]  dividend,
	input  logic [31:0]                  divisor,
	output logic                         done,
	output rcpc_pkg::quo_t               quo
);

	logic [31:0]                 rem_q;
	logic [rcpc_pkg::QUO_W-1:0]  dvd_q;
	logic [rcpc_pkg::QUO_W-1:0]  quo_q;
	logic [4:0]                  cnt_q;
	logic                        run_q;
	logic                        sat_q;
	logic                        done_q;
	logic [31:0]                 hi;
	logic [32:0]                 trial;
	logic                        take;

	always_comb begin
		hi    = 32'(dividend[rcpc_pkg::DIVD_W-1:rcpc_pkg::QUO_W]);
		trial = {rem_q, dvd_q[rcpc_pkg::QUO_W-1]};
		take  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (hi >= divisor) begin
					done_q <= 1'b1;
					run_q  <= 1'b0;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(rcpc_pkg::QUO_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= hi >= divisor;
			rem_q <= hi;
			dvd_q <= dividend[rcpc_pkg::QUO_W-1:0];
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? 32'(trial - {1'b0, divisor}) : trial[31:0];
			dvd_q <= {dvd_q[rcpc_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[rcpc_pkg::QUO_W-2:0], take};
		end
	end

	assign done    = done_q;
	assign quo.sat = sat_q;
	assign quo.mag = quo_q;

endmodule

// ----- rtl/core/ray_convex_polygon_clip_unit.sv -----
// ray_convex_polygon_clip_unit: Cyrus-Beck ray cast against a convex polygon, Q16.16
// depends on rcpc_pkg, rcpc_if and rcpc_div
//
// Face and transform beats are stored when they are accepted. A ray beat is worked by one shared
// 33x33 multiplier (two register stages) under a small sequencer, plus a one bit a
// cycle divider: the ray is mapped into body space, each face is evaluated, a
// division follows for each face whose quotient moves an interval bound, and the entry
// normal is rotated back to world space. The unit takes no new beat while a
// ray is in work; a finished result waits in the output register while the next beat
// is taken.
module ray_convex_polygon_clip_unit (
	input  logic              clk,
	input  logic              arst_n,
	rcpc_cmd_if.sink          cmd,
	rcpc_res_if.source        res
);

	localparam int FW = rcpc_pkg::FRAC_BITS;
	localparam int IW = rcpc_pkg::FACE_IDX_W;
	localparam int CW = rcpc_pkg::CNT_W;

	rcpc_pkg::state_t state_q, state_d;

	logic signed [31:0] vx_q [rcpc_pkg::MAX_FACES];
	logic signed [31:0] vy_q [rcpc_pkg::MAX_FACES];
	logic signed [31:0] nx_q [rcpc_pkg::MAX_FACES];
	logic signed [31:0] ny_q [rcpc_pkg::MAX_FACES];

	logic signed [31:0] pos_x_q, pos_y_q, cos_q, sin_q;
	logic signed [31:0] dx_q, dy_q, rdx_q, rdy_q;
	logic signed [31:0] px_q, py_q, tx_q, ty_q;
	logic signed [31:0] num_q, den_q, fnx_q, fny_q, wx_q, wy_q;
	logic signed [31:0] upper_q;
	logic [30:0]        lower_q;
	logic [CW-1:0]      cnt_q, face_q;
	logic               found_q, hit_q;
	logic [2:0]         op_q;
	logic               issued_q;
	logic signed [rcpc_pkg::ACC_W-1:0] acc_q;

	logic signed [32:0]                 a_s1, b_s1;
	rcpc_pkg::mtag_t                    tag_s1, tag_s2;
	logic signed [rcpc_pkg::PROD_W-1:0] prod_s2;

	logic               out_vld_q, out_hit_q;
	logic [30:0]        out_frac_q;
	logic signed [31:0] out_nx_q, out_ny_q;

	logic               accept, pass_done, cmp_lt, last_op, neg_op, div_start, div_done;
	logic [2:0]         n_last;
	logic [IW-1:0]      fi;
	logic [CW-1:0]      face_nx;
	logic signed [32:0] opa, opb;
	logic signed [rcpc_pkg::FQ_W-1:0]   fq;
	logic signed [rcpc_pkg::ACC_W-1:0]  sum;
	logic signed [31:0]                 res32;
	logic signed [rcpc_pkg::PROD_W-1:0] scaled;
	logic [31:0]        abs_num, abs_den;
	logic               miss_bound;
	rcpc_pkg::quo_t     quo;

	rcpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({abs_num, FW'(0)}),
		.divisor  (abs_den),
		.done     (div_done),
		.quo      (quo)
	);

	always_comb begin
		fi         = face_q[IW-1:0];
		face_nx    = face_q + CW'(1);
		pass_done  = tag_s2.vld && tag_s2.last;
		scaled     = {{(rcpc_pkg::PROD_W - 32 - FW){num_q[31]}}, num_q, FW'(0)};
		cmp_lt     = scaled < prod_s2;
		abs_num    = num_q[31] ? (~num_q + 32'd1) : num_q;
		abs_den    = den_q[31] ? (~den_q + 32'd1) : den_q;
		miss_bound = upper_q < $signed({1'b0, lower_q});
		fq         = prod_s2[rcpc_pkg::PROD_W-1:FW];
		sum        = neg_op ? (acc_q - {fq[rcpc_pkg::FQ_W-1], fq})
			: (acc_q + {fq[rcpc_pkg::FQ_W-1], fq});
		res32      = rcpc_pkg::sat32(sum);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcpc_pkg::ST_IDLE: begin
				if (accept && cmd.kind == rcpc_pkg::KIND_RAY) state_d = rcpc_pkg::ST_LOCAL;
			end
			rcpc_pkg::ST_LOCAL: begin
				if (pass_done)
					state_d = (cnt_q == '0) ? rcpc_pkg::ST_DONE : rcpc_pkg::ST_FACE;
			end
			rcpc_pkg::ST_FACE: begin
				if (pass_done) state_d = rcpc_pkg::ST_EVAL;
			end
			rcpc_pkg::ST_EVAL: begin
				if (den_q == '0)
					state_d = num_q[31] ? rcpc_pkg::ST_DONE : rcpc_pkg::ST_NEXT;
				else
					state_d = rcpc_pkg::ST_CMP;
			end
			rcpc_pkg::ST_CMP: begin
				if (pass_done) state_d = cmp_lt ? rcpc_pkg::ST_DIV : rcpc_pkg::ST_NEXT;
			end
			rcpc_pkg::ST_DIV: begin
				if (div_done) state_d = rcpc_pkg::ST_NEXT;
			end
			rcpc_pkg::ST_NEXT: begin
				if (miss_bound) state_d = rcpc_pkg::ST_DONE;
				else if (face_nx == cnt_q)
					state_d = found_q ? rcpc_pkg::ST_WORLD : rcpc_pkg::ST_DONE;
				else state_d = rcpc_pkg::ST_FACE;
			end
			rcpc_pkg::ST_WORLD: begin
				if (pass_done) state_d = rcpc_pkg::ST_DONE;
			end
			rcpc_pkg::ST_DONE: begin
				if (!out_vld_q || res.ready) state_d = rcpc_pkg::ST_IDLE;
			end
			default: state_d = rcpc_pkg::ST_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		cmd.ready = state_q == rcpc_pkg::ST_IDLE;
		accept    = cmd.valid && cmd.ready;
		div_start = state_q == rcpc_pkg::ST_CMP && pass_done && cmp_lt;
		opa       = '0;
		opb       = '0;
		n_last    = 3'd3;
		unique case (state_q)
			rcpc_pkg::ST_LOCAL: begin
				n_last = 3'd7;
				opa    = rcpc_pkg::ext33(op_q[0] ? sin_q : cos_q);
				unique case (op_q)
					3'd0: opb = rcpc_pkg::ext33(dx_q);
					3'd1: opb = rcpc_pkg::ext33(dy_q);
					3'd2: opb = rcpc_pkg::ext33(dy_q);
					3'd3: opb = rcpc_pkg::ext33(dx_q);
					3'd4: opb = rcpc_pkg::ext33(rdx_q);
					3'd5: opb = rcpc_pkg::ext33(rdy_q);
					3'd6: opb = rcpc_pkg::ext33(rdy_q);
					default: opb = rcpc_pkg::ext33(rdx_q);
				endcase
			end
			rcpc_pkg::ST_FACE: begin
				opa = rcpc_pkg::ext33(op_q[0] ? ny_q[fi] : nx_q[fi]);
				unique case (op_q[1:0])
					2'd0: opb = rcpc_pkg::ext33(vx_q[fi]) - rcpc_pkg::ext33(px_q);
					2'd1: opb = rcpc_pkg::ext33(vy_q[fi]) - rcpc_pkg::ext33(py_q);
					2'd2: opb = rcpc_pkg::ext33(tx_q);
					default: opb = rcpc_pkg::ext33(ty_q);
				endcase
			end
			rcpc_pkg::ST_CMP: begin
				n_last = 3'd0;
				opa    = rcpc_pkg::ext33(den_q);
				opb    = den_q[31] ? $signed({2'b00, lower_q}) : rcpc_pkg::ext33(upper_q);
			end
			rcpc_pkg::ST_WORLD: begin
				opa = rcpc_pkg::ext33((op_q[1] ^ op_q[0]) ? sin_q : cos_q);
				opb = rcpc_pkg::ext33(op_q[0] ? fny_q : fnx_q);
			end
			default: begin
				opa = '0;
			end
		endcase
		last_op = op_q == n_last;
		neg_op  = (state_q == rcpc_pkg::ST_LOCAL && tag_s2.op[1:0] == 2'd3)
			|| (state_q == rcpc_pkg::ST_WORLD && tag_s2.op[1:0] == 2'd1);
		res.valid    = out_vld_q;
		res.hit      = out_hit_q;
		res.fraction = out_frac_q;
		res.normal_x = out_nx_q;
		res.normal_y = out_ny_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rcpc_pkg::ST_IDLE;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			cos_q     <= 32'sd1 <<< FW;
			sin_q     <= '0;
			tag_s1    <= '0;
			tag_s2    <= '0;
			op_q      <= '0;
			issued_q  <= 1'b0;
			out_vld_q <= 1'b0;
			face_q    <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			tag_s2  <= tag_s1;
			if (state_d != state_q) begin
				op_q     <= '0;
				issued_q <= 1'b0;
			end
			tag_s1.vld <= 1'b0;
			if ((state_q == rcpc_pkg::ST_LOCAL || state_q == rcpc_pkg::ST_FACE
				|| state_q == rcpc_pkg::ST_CMP || state_q == rcpc_pkg::ST_WORLD)
				&& !issued_q) begin
				tag_s1 <= '{vld: 1'b1, last: last_op, op: op_q};
				op_q   <= op_q + 3'd1;
				if (last_op) issued_q <= 1'b1;
			end
			if (accept && cmd.kind == rcpc_pkg::KIND_XFORM) begin
				pos_x_q <= cmd.x_a;
				pos_y_q <= cmd.y_a;
				cos_q   <= cmd.x_b;
				sin_q   <= cmd.y_b;
			end
			if (accept && cmd.kind == rcpc_pkg::KIND_RAY) begin
				face_q  <= '0;
				found_q <= 1'b0;
				hit_q   <= 1'b0;
				cnt_q   <= (32'(cmd.face_count) > rcpc_pkg::MAX_FACES)
					? CW'(rcpc_pkg::MAX_FACES) : CW'(cmd.face_count);
			end
			if (state_q == rcpc_pkg::ST_DIV && div_done && den_q[31]) found_q <= 1'b1;
			if (state_q == rcpc_pkg::ST_NEXT) face_q <= face_nx;
			if (state_q == rcpc_pkg::ST_WORLD && pass_done) hit_q <= 1'b1;
			if (state_q == rcpc_pkg::ST_DONE && state_d == rcpc_pkg::ST_IDLE)
				out_vld_q <= 1'b1;
			else if (res.ready)
				out_vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept && cmd.kind == rcpc_pkg::KIND_FACE
			&& 32'(cmd.face_slot) < rcpc_pkg::MAX_FACES) begin
			vx_q[IW'(cmd.face_slot)] <= cmd.x_a;
			vy_q[IW'(cmd.face_slot)] <= cmd.y_a;
			nx_q[IW'(cmd.face_slot)] <= cmd.x_b;
			ny_q[IW'(cmd.face_slot)] <= cmd.y_b;
		end
		if (accept && cmd.kind == rcpc_pkg::KIND_RAY) begin
			dx_q    <= rcpc_pkg::sat32(rcpc_pkg::ACC_W'(cmd.x_a) - rcpc_pkg::ACC_W'(pos_x_q));
			dy_q    <= rcpc_pkg::sat32(rcpc_pkg::ACC_W'(cmd.y_a) - rcpc_pkg::ACC_W'(pos_y_q));
			rdx_q   <= cmd.x_b;
			rdy_q   <= cmd.y_b;
			lower_q <= '0;
			upper_q <= $signed({1'b0, cmd.max_fraction});
		end
		a_s1    <= opa;
		b_s1    <= opb;
		prod_s2 <= a_s1 * b_s1;
		if (tag_s2.vld && state_q != rcpc_pkg::ST_CMP) begin
			if (!tag_s2.op[0]) begin
				acc_q <= {fq[rcpc_pkg::FQ_W-1], fq};
			end else begin
				unique case (state_q)
					rcpc_pkg::ST_LOCAL: begin
						unique case (tag_s2.op[2:1])
							2'd0: px_q <= res32;
							2'd1: py_q <= res32;
							2'd2: tx_q <= res32;
							default: ty_q <= res32;
						endcase
					end
					rcpc_pkg::ST_FACE: begin
						if (tag_s2.op[1]) den_q <= res32;
						else num_q <= res32;
					end
					rcpc_pkg::ST_WORLD: begin
						if (tag_s2.op[1]) wy_q <= res32;
						else wx_q <= res32;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
		if (state_q == rcpc_pkg::ST_DIV && div_done) begin
			if (den_q[31]) begin
				lower_q <= quo.sat ? rcpc_pkg::MAX_Q31 : quo.mag;
				fnx_q   <= nx_q[fi];
				fny_q   <= ny_q[fi];
			end else if (num_q[31]) begin
				upper_q <= (quo.sat || quo.mag != '0) ? -32'sd1 : 32'sd0;
			end else begin
				upper_q <= $signed({1'b0, quo.mag});
			end
		end
		if (state_q == rcpc_pkg::ST_DONE && state_d == rcpc_pkg::ST_IDLE) begin
			out_hit_q  <= hit_q;
			out_frac_q <= hit_q ? lower_q : '0;
			out_nx_q   <= hit_q ? wx_q : '0;
			out_ny_q   <= hit_q ? wy_q : '0;
		end
	end

endmodule
